### hdl/flds_pkg.sv
package flds_pkg;

    // LINE_DEPTH must be a power of two: read positions wrap by truncation.
    localparam int LINE_DEPTH = 1024;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int FRAC_W     = 16;
    localparam int POS_W      = LINE_AW + FRAC_W;

    localparam int SAMPLE_W   = 16;
    localparam int DELAY_W    = 25;
    localparam int STEP_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int SWEEP_W    = 26;
    localparam int TOT_W      = (POS_W > SWEEP_W + 1) ? POS_W : SWEEP_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    localparam int MUL_W      = 18;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int SAT_W      = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_MAX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX        = 3'd4;

    localparam logic [DELAY_W-1:0] RST_BASE_DELAY = 25'd2955264;
    localparam logic [STEP_W-1:0]  RST_SWEEP_STEP = 16'd4096;
    localparam logic [DELAY_W-1:0] RST_SWEEP_MAX  = 25'd14450688;
    localparam logic [GAIN_W-1:0]  RST_FEEDBACK   = 16'd24576;
    localparam logic [GAIN_W-1:0]  RST_MIX        = 16'd32768;

    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_W'(1 << (SAMPLE_W - 1));

    typedef struct packed {
        logic clear;
        logic advance;
    } sweep_ctl_t;

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [SAT_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[SAMPLE_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[SAMPLE_W-1:0];
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

### hdl/flds_ram.sv
module flds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/flds_mul.sv
module flds_mul import flds_pkg::*; (
    input  logic                     aclk,
    input  logic signed [MUL_W-1:0]  op_a,
    input  logic signed [MUL_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

### hdl/flds_sweep.sv
module flds_sweep import flds_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  sweep_ctl_t         ctl,
    input  logic [STEP_W-1:0]  step,
    input  logic [DELAY_W-1:0] sweep_max,
    output logic [SWEEP_W-1:0] sweep_pos
);

    logic [SWEEP_W-1:0]        pos_reg;
    logic                      down_reg;
    logic signed [SWEEP_W+1:0] pos_ext;
    logic signed [SWEEP_W+1:0] step_ext;
    logic signed [SWEEP_W+1:0] max_ext;
    logic signed [SWEEP_W+1:0] moved;

    assign pos_ext  = $signed({2'b00, pos_reg});
    assign step_ext = $signed({{(SWEEP_W + 2 - STEP_W){1'b0}}, step});
    assign max_ext  = $signed({{(SWEEP_W + 2 - DELAY_W){1'b0}}, sweep_max});
    assign moved    = down_reg ? pos_ext - step_ext : pos_ext + step_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            down_reg <= 1'b0;
        end else if (ctl.clear) begin
            pos_reg  <= '0;
            down_reg <= 1'b0;
        end else if (ctl.advance && step != '0) begin
            if (moved <= 0) begin
                pos_reg  <= '0;
                down_reg <= !down_reg;
            end else begin
                pos_reg <= moved[SWEEP_W-1:0];
                if (moved >= max_ext) begin
                    down_reg <= !down_reg;
                end
            end
        end
    end

    assign sweep_pos = pos_reg;

endmodule

### hdl/flanger_delay_sweep.sv
// Mono flanger on signed Q1.15 samples. After reset the block clears its 1024-entry delay
// line, one entry per cycle, and keeps s_tready low until it is clear; register writes
// are taken meanwhile. A sample is taken in IDLE, then states WR, RD1, RD2, INT, WET, MIX
// and OUT run before the next is taken: the accepting cycle runs the feedback product, and
// after it s_tready stays low while the sequencer runs the delay-line write, two reads from
// the single read port of the line memory, the interpolation product and the mix product
// through one shared 18x18 multiplier, and loads the output register. The result sits in
// that register, so the next sample can be accepted while it waits; if a result is still
// waiting when the following sample finishes, the sequencer holds in its last step until
// m_tready takes the waiting one. Write registers only while the block is idle.
module flanger_delay_sweep import flds_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,   // [15:0] sample_in
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SAMPLE_W-1:0]   m_tdata,   // [15:0] sample_out
    output logic                  m_tlast
);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_WR    = 4'd2;
    localparam logic [3:0] ST_RD1   = 4'd3;
    localparam logic [3:0] ST_RD2   = 4'd4;
    localparam logic [3:0] ST_INT   = 4'd5;
    localparam logic [3:0] ST_WET   = 4'd6;
    localparam logic [3:0] ST_MIX   = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    localparam logic signed [PROD_W-1:0] Q15_HALF = PROD_W'(1 << 14);
    localparam logic signed [PROD_W-1:0] Q16_HALF = PROD_W'(1 << 15);

    logic [3:0]                 state_reg;
    logic [3:0]                 state_next;
    logic [LINE_AW-1:0]         clr_cnt_reg;
    logic [LINE_AW-1:0]         wi_reg;
    logic [POS_W-1:0]           total_reg;
    logic [LINE_AW-1:0]         r1_reg;
    logic [LINE_AW-1:0]         r2_reg;
    logic [FRAC_W-1:0]          frac_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic                       last_reg;
    logic signed [SAMPLE_W-1:0] d1_reg;
    logic signed [SAMPLE_W-1:0] wet_reg;

    logic [DELAY_W-1:0]         base_delay_reg;
    logic [STEP_W-1:0]          sweep_step_reg;
    logic [DELAY_W-1:0]         sweep_max_reg;
    logic signed [GAIN_W-1:0]   feedback_reg;
    logic [GAIN_W-1:0]          mix_reg;

    logic                       m_valid_reg;
    logic [SAMPLE_W-1:0]        m_data_reg;
    logic                       m_last_reg;

    logic                       accept;
    logic                       out_load;
    logic [SWEEP_W-1:0]         sweep_pos;
    sweep_ctl_t                 sweep_ctl;
    logic [TOT_W-1:0]           delay_sum;
    logic [POS_W-1:0]           read_pos;

    logic signed [MUL_W-1:0]    op_a;
    logic signed [MUL_W-1:0]    op_b;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   q15_sum;
    logic signed [PROD_W-1:0]   q15_shr;
    logic signed [SAT_W-1:0]    x_ext;
    logic signed [SAT_W-1:0]    dry_sum;
    logic signed [PROD_W-1:0]   interp_acc;
    logic signed [PROD_W-1:0]   interp_shr;
    logic signed [SAMPLE_W:0]   d_diff;

    logic                       ram_we;
    logic [LINE_AW-1:0]         ram_waddr;
    logic [SAMPLE_W-1:0]        ram_wdata;
    logic [LINE_AW-1:0]         ram_raddr;
    logic [SAMPLE_W-1:0]        ram_rdata;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);

    assign delay_sum = TOT_W'(base_delay_reg) + TOT_W'(sweep_pos);
    assign read_pos  = {wi_reg, {FRAC_W{1'b0}}} - total_reg;

    assign q15_sum = prod + Q15_HALF;
    assign q15_shr = q15_sum >>> 15;
    assign x_ext   = {{(SAT_W - SAMPLE_W){x_reg[SAMPLE_W-1]}}, x_reg};
    assign dry_sum = x_ext + $signed(q15_shr[SAT_W-1:0]);

    assign interp_acc = $signed({{(PROD_W - SAMPLE_W - FRAC_W){d1_reg[SAMPLE_W-1]}},
                                 d1_reg, {FRAC_W{1'b0}}}) + prod + Q16_HALF;
    assign interp_shr = interp_acc >>> FRAC_W;
    assign d_diff     = $signed({ram_rdata[SAMPLE_W-1], ram_rdata})
                      - $signed({d1_reg[SAMPLE_W-1], d1_reg});

    assign sweep_ctl.clear   = cfg_we && (cfg_index == CFG_SWEEP_STEP ||
                                          cfg_index == CFG_SWEEP_MAX);
    assign sweep_ctl.advance = (state_reg == ST_WR);

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            ST_IDLE: begin
                op_a = MUL_W'(feedback_reg);
                op_b = MUL_W'(wet_reg);
            end
            ST_INT: begin
                op_a = MUL_W'(d_diff);
                op_b = $signed({{(MUL_W - FRAC_W){1'b0}}, frac_reg});
            end
            ST_MIX, ST_OUT: begin
                op_a = $signed({{(MUL_W - GAIN_W){1'b0}}, mix_reg});
                op_b = MUL_W'(wet_reg);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = wi_reg;
        ram_wdata = sat_sample(dry_sum);
        ram_raddr = (state_reg == ST_RD1) ? r1_reg : r2_reg;
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end else if (state_reg == ST_WR) begin
            ram_we = 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == LINE_AW'(LINE_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_WR;
                end
            end
            ST_WR:  state_next = ST_RD1;
            ST_RD1: state_next = ST_RD2;
            ST_RD2: state_next = ST_INT;
            ST_INT: state_next = ST_WET;
            ST_WET: state_next = ST_MIX;
            ST_MIX: state_next = ST_OUT;
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            wi_reg         <= '0;
            wet_reg        <= '0;
            m_valid_reg    <= 1'b0;
            base_delay_reg <= RST_BASE_DELAY;
            sweep_step_reg <= RST_SWEEP_STEP;
            sweep_max_reg  <= RST_SWEEP_MAX;
            feedback_reg   <= RST_FEEDBACK;
            mix_reg        <= RST_MIX;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + LINE_AW'(1);
            end
            if (accept) begin
                wi_reg <= wi_reg + LINE_AW'(1);
            end
            if (state_reg == ST_WET) begin
                wet_reg <= sat_sample(interp_shr[SAT_W-1:0]);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_BASE_DELAY: base_delay_reg <= cfg_wdata[DELAY_W-1:0];
                    CFG_SWEEP_STEP: sweep_step_reg <= cfg_wdata[STEP_W-1:0];
                    CFG_SWEEP_MAX:  sweep_max_reg  <= cfg_wdata[DELAY_W-1:0];
                    CFG_FEEDBACK:   feedback_reg   <= cfg_wdata[GAIN_W-1:0];
                    CFG_MIX:        mix_reg        <= cfg_wdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg     <= s_tdata;
            last_reg  <= s_tlast;
            total_reg <= delay_sum[POS_W-1:0];
        end
        if (state_reg == ST_WR) begin
            r1_reg   <= read_pos[POS_W-1:FRAC_W] + LINE_AW'(1);
            frac_reg <= read_pos[FRAC_W-1:0];
        end
        if (state_reg == ST_RD1) begin
            r2_reg <= r1_reg + LINE_AW'(1);
        end
        if (state_reg == ST_RD2) begin
            d1_reg <= ram_rdata;
        end
        if (out_load) begin
            m_data_reg <= sat_sample(dry_sum);
            m_last_reg <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    flds_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    flds_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    flds_sweep u_sweep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (sweep_ctl),
        .step      (sweep_step_reg),
        .sweep_max (sweep_max_reg),
        .sweep_pos (sweep_pos)
    );

endmodule

### hdl/flds_chk.sv
module flds_chk import flds_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [SAMPLE_W-1:0] m_tdata,
    input logic                m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_busy_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("ready returned too early after a request");

    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("ready high during delay line clear");

    a_result_ends_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result shown while sequencer still busy");

endmodule

bind flanger_delay_sweep flds_chk u_flds_chk (.*);

### tb/tb_flanger_delay_sweep.sv
`timescale 1ns / 1ps

module tb_flanger_delay_sweep;
    import flds_pkg::*;

    typedef struct packed {
        logic                last;
        logic [SAMPLE_W-1:0] sample;
    } frame_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata   = '0;   // [15:0] sample_in
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [SAMPLE_W-1:0]   m_tdata;          // [15:0] sample_out
    logic                  m_tlast;

    flanger_delay_sweep dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #1 aclk = ~aclk;

    // flanger state and registers as seen from outside
    logic signed [SAMPLE_W-1:0] line_mem [LINE_DEPTH];
    logic [LINE_AW-1:0]         wr_ptr;
    logic signed [SAMPLE_W-1:0] wet_reg;
    longint                     sweep_acc;
    bit                         sweep_dn;
    logic [DELAY_W-1:0]         base_cfg;
    logic [STEP_W-1:0]          step_cfg;
    logic [DELAY_W-1:0]         max_cfg;
    logic signed [GAIN_W-1:0]   fb_cfg;
    logic [GAIN_W-1:0]          mix_cfg;

    frame_t sample_queue [$];
    frame_t expected_out [$];
    frame_t pend;
    frame_t want;

    int  req_in_count = 0;
    int  res_count    = 0;
    int  fail_count   = 0;
    int  sat_hits     = 0;
    int  cfg_writes   = 0;
    int  settings_run = 0;
    int  hold_left    = 0;
    bit  hold_done    = 1'b0;
    logic calm;

    assign calm = (req_in_count >= 1200) && (req_in_count < 1500);

    function automatic longint q15_product(longint a, longint b);
        return (a * b + 16384) >>> 15;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] clip16(longint v);
        if (v > 32767) return 16'h7FFF;
        if (v < -32768) return 16'h8000;
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic logic [SAMPLE_W-1:0] flange_sample(logic signed [SAMPLE_W-1:0] x);
        logic [POS_W-1:0]           rd_pos;
        logic [LINE_AW-1:0]         tap_a;
        logic [LINE_AW-1:0]         tap_b;
        longint                     frac;
        longint                     acc;
        logic signed [SAMPLE_W-1:0] y;
        wr_ptr = wr_ptr + 1'b1;
        rd_pos = {wr_ptr, {FRAC_W{1'b0}}} - POS_W'(longint'(base_cfg) + sweep_acc);
        tap_a  = rd_pos[POS_W-1:FRAC_W] + 1'b1;
        tap_b  = tap_a + 1'b1;
        frac   = rd_pos[FRAC_W-1:0];
        line_mem[wr_ptr] = clip16(longint'(x) + q15_product(fb_cfg, wet_reg));
        acc = longint'(line_mem[tap_a]) * (65536 - frac)
            + longint'(line_mem[tap_b]) * frac + 32768;
        wet_reg = clip16(acc >>> 16);
        y = clip16(longint'(x) + q15_product(longint'(mix_cfg), wet_reg));
        if (step_cfg != 0) begin
            if (sweep_dn) begin
                sweep_acc = sweep_acc - longint'(step_cfg);
            end else begin
                sweep_acc = sweep_acc + longint'(step_cfg);
            end
            if (sweep_acc <= 0) begin
                sweep_acc = 0;
                sweep_dn  = !sweep_dn;
            end else if (sweep_acc >= longint'(max_cfg)) begin
                sweep_dn = !sweep_dn;
            end
        end
        return y;
    endfunction

    function automatic frame_t rand_frame();
        frame_t f;
        int     pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            f.sample = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        end else if (pick < 35) begin
            f.sample = 16'($urandom_range(511) - 256);
        end else begin
            f.sample = 16'($urandom);
        end
        f.last = ($urandom_range(15) == 0);
        return f;
    endfunction

    task automatic add_sample(input frame_t f);
        sample_queue.insert(sample_queue.size(), f);
    endtask

    task automatic queue_random(input int n);
        repeat (n) add_sample(rand_frame());
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        cfg_writes++;
        case (idx)
            CFG_BASE_DELAY: base_cfg = val[DELAY_W-1:0];
            CFG_SWEEP_STEP: begin
                step_cfg  = val[STEP_W-1:0];
                sweep_acc = 0;
                sweep_dn  = 1'b0;
            end
            CFG_SWEEP_MAX: begin
                max_cfg   = val[DELAY_W-1:0];
                sweep_acc = 0;
                sweep_dn  = 1'b0;
            end
            CFG_FEEDBACK: fb_cfg  = val[GAIN_W-1:0];
            CFG_MIX:      mix_cfg = val[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    task automatic load_settings(input logic [DELAY_W-1:0] base, input logic [STEP_W-1:0] step,
                                 input logic [DELAY_W-1:0] smax, input logic [GAIN_W-1:0] fb,
                                 input logic [GAIN_W-1:0] mixv);
        write_reg(CFG_BASE_DELAY, base);
        write_reg(CFG_SWEEP_STEP, {9'($urandom), step});
        write_reg(CFG_SWEEP_MAX, smax);
        write_reg(CFG_FEEDBACK, {9'($urandom), fb});
        write_reg(CFG_MIX, {9'($urandom), mixv});
        end_writes();
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (sample_queue.size() != 0 || s_tvalid || expected_out.size() != 0);
        repeat (24) @(negedge aclk);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_out.insert(expected_out.size(),
                                    '{last: s_tlast, sample: flange_sample(s_tdata)});
                req_in_count <= req_in_count + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (sample_queue.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
                    pend = sample_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= pend.sample;
                    s_tlast  <= pend.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // hold off the receiver once while requests keep coming
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && req_in_count >= 400 && sample_queue.size() > 100) begin
            hold_left <= 600;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                res_count++;
                if (expected_out.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: sample_out %h last %b", m_tdata, m_tlast);
                end else begin
                    want = expected_out.pop_front();
                    if (m_tdata !== want.sample || m_tlast !== want.last) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch at result %0d: expected %h last %b, got %h last %b",
                                     res_count, want.sample, want.last, m_tdata, m_tlast);
                    end
                    if (want.sample == 16'h7FFF || want.sample == 16'h8000) sat_hits++;
                end
            end
            m_tready <= (hold_left == 0) && (calm || $urandom_range(99) >= 20);
        end
    end

    initial begin
        #1000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        foreach (line_mem[i]) line_mem[i] = '0;
        wr_ptr    = '0;
        wet_reg   = '0;
        sweep_acc = 0;
        sweep_dn  = 1'b0;
        base_cfg  = RST_BASE_DELAY;
        step_cfg  = RST_SWEEP_STEP;
        max_cfg   = RST_SWEEP_MAX;
        fb_cfg    = RST_FEEDBACK;
        mix_cfg   = RST_MIX;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // full scale, zero, one step off zero, runs of full scale into the feedback path
        add_sample('{last: 1'b0, sample: 16'h7FFF});
        add_sample('{last: 1'b1, sample: 16'h8000});
        add_sample('{last: 1'b0, sample: 16'h0000});
        add_sample('{last: 1'b0, sample: 16'hFFFF});
        add_sample('{last: 1'b1, sample: 16'h0001});
        repeat (6) add_sample('{last: 1'b0, sample: 16'h7FFF});
        repeat (6) add_sample('{last: 1'b0, sample: 16'h8000});
        for (int i = 0; i < 6; i++)
            add_sample('{last: 1'(i % 2), sample: (i % 2) ? 16'h8000 : 16'h7FFF});
        wait_drained();

        // shortest delay, sweep stopped, strongest positive feedback, unity mix
        load_settings(25'd65536, 16'd0, 25'd0, 16'h7FFF, 16'd32768);
        queue_random(200);
        wait_drained();

        // longest allowed delay and sweep, strongest negative feedback, mix above unity
        load_settings(25'd28966912, 16'hFFFF, 25'd28901376, 16'h8000, 16'hFFFF);
        queue_random(200);
        wait_drained();

        // total delay beyond the line, dry only; spare index ignored; pause mid-run
        load_settings(25'h1FFFFFF, 16'($urandom_range(65535, 1024)), 25'h1FFFFFF,
                      16'($urandom), 16'd0);
        write_reg(CFG_IDX_W'(CFG_MIX + 1 + $urandom_range(2)), 25'($urandom));
        end_writes();
        queue_random(100);
        wait_drained();
        queue_random(100);
        wait_drained();

        // zero delay, fast turnaround of a shallow sweep
        load_settings(25'd0, 16'd20000, 25'd196608, 16'($urandom), 16'($urandom_range(32768)));
        queue_random(200);
        wait_drained();

        // gains only: sweep carries on
        write_reg(CFG_FEEDBACK, 25'($urandom));
        write_reg(CFG_MIX, 25'($urandom));
        end_writes();
        queue_random(200);
        wait_drained();

        repeat (5) begin
            load_settings(25'($urandom_range(28966912, 65536)), 16'($urandom_range(8192)),
                          25'($urandom_range(28901376)), 16'($urandom),
                          16'($urandom_range(32768)));
            queue_random(200);
            wait_drained();
        end

        if (expected_out.size() != 0) begin
            fail_count++;
            $display("%0d expected results never arrived", expected_out.size());
        end
        $display("covered %0d samples over %0d register settings (%0d writes)",
                 req_in_count, settings_run, cfg_writes);
        $display("compared %0d results, %0d at full scale, %0d failures",
                 res_count, sat_hits, fail_count);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
